// ===== src/jacobi_symbol_unit_top_assert.svh =====
// Assertion macros shared by the jacobi symbol unit modules.
// Both expect i_clk and i_rst_n in scope.
`ifndef JACOBI_SYMBOL_UNIT_TOP_ASSERT_SVH
`define JACOBI_SYMBOL_UNIT_TOP_ASSERT_SVH

// same-cycle implication
`define JSU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("jsu assertion failed");

// next-cycle implication
`define JSU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("jsu assertion failed");

`endif

// ===== src/jsu_pkg.sv =====
package jsu_pkg;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mod_stat;

    typedef logic [1:0] t_symbol;

    localparam t_symbol SYM_ZERO = 2'b00;
    localparam t_symbol SYM_POS  = 2'b01;
    localparam t_symbol SYM_NEG  = 2'b11;

    localparam int OUT_TDATA_W = 8;

    // residues that flip the sign
    localparam logic [2:0] R8_FLIP_LO = 3'd3;
    localparam logic [2:0] R8_FLIP_HI = 3'd5;
    localparam logic [1:0] R4_THREE   = 2'd3;

endpackage

// ===== src/jsu_mod.sv =====
module jsu_mod #(
    parameter int OPERAND_WIDTH = 31
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [OPERAND_WIDTH-1:0] i_dividend,
    input  logic [OPERAND_WIDTH-1:0] i_divisor,
    output jsu_pkg::t_mod_stat       o_stat,
    output logic [OPERAND_WIDTH-1:0] o_rem
);
    import jsu_pkg::*;

    localparam int CNT_W = $clog2(OPERAND_WIDTH + 1);

    logic [OPERAND_WIDTH-1:0] r_rem, n_rem;
    logic [OPERAND_WIDTH-1:0] r_dvd;
    logic [OPERAND_WIDTH-1:0] r_div;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_done;

    logic [OPERAND_WIDTH:0]   w_trial;
    logic [OPERAND_WIDTH:0]   w_diff;
    logic                     w_ge;

    // radix-2 restoring step, one dividend bit per cycle
    always_comb begin
        w_trial = {r_rem, r_dvd[OPERAND_WIDTH-1]};
        w_ge    = (w_trial >= {1'b0, r_div});
        w_diff  = w_trial - {1'b0, r_div};
        n_rem   = w_ge ? w_diff[OPERAND_WIDTH-1:0] : w_trial[OPERAND_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem <= '0;
                r_dvd <= i_dividend;
                r_div <= i_divisor;
                r_cnt <= CNT_W'(OPERAND_WIDTH);
            end else if (r_cnt != '0) begin
                r_rem  <= n_rem;
                r_dvd  <= {r_dvd[OPERAND_WIDTH-2:0], 1'b0};
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == CNT_W'(1));
            end
        end
    end

    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;

`include "jacobi_symbol_unit_top_assert.svh"

    `JSU_ASSERT_IMP(a_rem_lt_div, r_done, r_rem < r_div)
    `JSU_ASSERT_NXT(a_start_busy, i_start, r_cnt != '0)
    `JSU_ASSERT_IMP(a_no_restart, i_start, r_cnt == '0)

endmodule

// ===== src/jacobi_symbol_unit_top.sv =====
// Jacobi symbol unit: each input beat carries a value and a modulus and yields one output
// beat with the symbol (-1, 0, +1, two's complement in the low two bits, zero-extended) and a
// flag for a zero modulus. Items are processed one at a time. Every modulo reduction runs on
// a bit-serial shift-subtract unit; factors of two are stripped from the value one at a time,
// and each reciprocity swap starts the reduction of the new pair.
// A finished result sits in the output register while the next beat is accepted.
module jacobi_symbol_unit_top #(
    parameter int OPERAND_WIDTH = 31,
    localparam int S_TDATA_W = ((2 * OPERAND_WIDTH + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [S_TDATA_W-1:0]            i_s_axis_tdata,  // value, modulus
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [jsu_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,  // symbol
    output logic [0:0]                      o_m_axis_tuser   // bad_modulus
);
    import jsu_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_STRIP,
        S_DONE
    } t_state;

    t_state                   r_state;
    logic [OPERAND_WIDTH-1:0] r_a;
    logic [OPERAND_WIDTH-1:0] r_p;
    logic                     r_neg;
    logic                     r_first;
    t_symbol                  r_sym;
    logic                     r_bad;
    logic                     r_out_valid;
    t_symbol                  r_out_sym;
    logic                     r_out_bad;

    logic [OPERAND_WIDTH-1:0] w_in_a;
    logic [OPERAND_WIDTH-1:0] w_in_p;
    logic                     w_accept;
    logic                     w_start;
    logic [OPERAND_WIDTH-1:0] w_dividend;
    logic [OPERAND_WIDTH-1:0] w_divisor;
    t_mod_stat                w_mod_stat;
    logic [OPERAND_WIDTH-1:0] w_rem;

    assign w_in_a   = i_s_axis_tdata[OPERAND_WIDTH-1:0];
    assign w_in_p   = i_s_axis_tdata[2*OPERAND_WIDTH-1:OPERAND_WIDTH];
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        w_start    = (w_accept && (w_in_p != '0)) || ((r_state == S_STRIP) && r_a[0]);
        w_dividend = (r_state == S_IDLE) ? w_in_a : r_p;
        w_divisor  = (r_state == S_IDLE) ? w_in_p : r_a;
    end

    jsu_mod #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_stat     (w_mod_stat),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_neg   <= 1'b0;
                        r_first <= 1'b1;
                        r_p     <= w_in_p;
                        if (w_in_p == '0) begin
                            r_sym   <= SYM_ZERO;
                            r_bad   <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_bad   <= 1'b0;
                            r_state <= S_MOD;
                        end
                    end
                end
                S_MOD: begin
                    if (w_mod_stat.done) begin
                        r_a     <= w_rem;
                        r_first <= 1'b0;
                        if (w_rem == '0) begin
                            if (!r_first && (r_p == OPERAND_WIDTH'(1))) begin
                                r_sym <= r_neg ? SYM_NEG : SYM_POS;
                            end else begin
                                r_sym <= SYM_ZERO;
                            end
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_STRIP;
                        end
                    end
                end
                S_STRIP: begin
                    if (!r_a[0]) begin
                        r_a <= {1'b0, r_a[OPERAND_WIDTH-1:1]};
                        if ((r_p[2:0] == R8_FLIP_LO) || (r_p[2:0] == R8_FLIP_HI)) begin
                            r_neg <= ~r_neg;
                        end
                    end else begin
                        // reciprocity swap; reduction of the new pair starts now
                        r_a <= r_p;
                        r_p <= r_a;
                        if ((r_a[1:0] == R4_THREE) && (r_p[1:0] == R4_THREE)) begin
                            r_neg <= ~r_neg;
                        end
                        r_state <= S_MOD;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_sym   <= r_sym;
                        r_out_bad   <= r_bad;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready   = (r_state == S_IDLE);
    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = {{(OUT_TDATA_W - 2){1'b0}}, r_out_sym};
    assign o_m_axis_tuser[0] = r_out_bad;

`include "jacobi_symbol_unit_top_assert.svh"

    `JSU_ASSERT_IMP(a_idle_mod_free, r_state == S_IDLE, !w_mod_stat.busy)
    `JSU_ASSERT_IMP(a_done_in_mod, w_mod_stat.done, r_state == S_MOD)
    `JSU_ASSERT_IMP(a_bad_zero, r_out_valid && r_out_bad, r_out_sym == SYM_ZERO)
    `JSU_ASSERT_IMP(a_sym_legal, r_out_valid, r_out_sym != 2'b10)

endmodule
